@@ rtl/core/ps2_mouse_packet_tracker_unit_defines.svh @@
// ----------------------------------------------------------------------------
// ps2 mouse packet tracker assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_TRACKER_UNIT_DEFINES_SVH
`define PS2_MOUSE_PACKET_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PMT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define PMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/pmt_pkg.sv @@
// ----------------------------------------------------------------------------
// pmt_pkg
// types, constants and helpers shared by the ps2 mouse packet tracker
// ----------------------------------------------------------------------------
package pmt_pkg;

	// coordinate and register widths
	localparam int POS_W          = 12;
	localparam int COORD_BITS_DEF = 12;
	localparam int CFG_IDX_W      = 1;

	// register indices
	localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 1'd1;

	// reset values
	localparam logic [POS_W-1:0] MAX_X_RST = 12'd1024;
	localparam logic [POS_W-1:0] MAX_Y_RST = 12'd768;
	localparam int               CUR_X_RST = 512;
	localparam int               CUR_Y_RST = 384;

	// header byte bit positions
	localparam int HDR_SYNC_BIT = 3;
	localparam int HDR_XOVF_BIT = 6;
	localparam int HDR_YOVF_BIT = 7;
	localparam int LEFT_BIT     = 0;

	// one assembled packet
	typedef struct packed {
		logic [7:0] header;
		logic [7:0] x_byte;
		logic [7:0] y_byte;
	} packet_t;

	// one decoded result
	typedef struct packed {
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [7:0]       delta_x;
		logic [7:0]       delta_y;
		logic [2:0]       buttons;
		logic             left_went_down;
		logic             left_went_up;
		logic             moved;
	} result_t;

	// saturate a signed sum to the range zero to lim
	function automatic logic [POS_W-1:0] clamp_pos(logic signed [POS_W+1:0] v,
			logic [POS_W-1:0] lim);
		logic [POS_W-1:0] r;
		if (v[POS_W+1]) begin
			r = '0;
		end else if (v[POS_W:0] > {1'b0, lim}) begin
			r = lim;
		end else begin
			r = v[POS_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/core/pmt_assembler.sv @@
// ----------------------------------------------------------------------------
// pmt_assembler
// byte phase tracking and header synchronisation for three-byte packets
// ----------------------------------------------------------------------------
module pmt_assembler (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [7:0]       data_byte,
	output logic             emit,
	output pmt_pkg::packet_t pkt
);
	import pmt_pkg::*;

	localparam logic [1:0] PH_HDR = 2'd0;
	localparam logic [1:0] PH_X   = 2'd1;
	localparam logic [1:0] PH_Y   = 2'd2;

	logic [1:0] phase_q;
	logic [7:0] header_q;
	logic [7:0] x_byte_q;

	// phase three behaves like the last byte
	assign emit = (phase_q != PH_HDR) && (phase_q != PH_X);

	assign pkt.header = header_q;
	assign pkt.x_byte = x_byte_q;
	assign pkt.y_byte = data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
		end else if (en) begin
			case (phase_q)
				PH_HDR: begin
					if (data_byte[HDR_SYNC_BIT]) phase_q <= PH_X;
				end
				PH_X: begin
					phase_q <= PH_Y;
				end
				PH_Y: begin
					phase_q <= PH_HDR;
				end
				default: begin
					phase_q <= PH_HDR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en && phase_q == PH_HDR && data_byte[HDR_SYNC_BIT]) header_q <= data_byte;
		if (en && phase_q == PH_X) x_byte_q <= data_byte;
	end

endmodule

@@ rtl/core/pmt_cursor.sv @@
// ----------------------------------------------------------------------------
// pmt_cursor
// movement decode, clamped cursor update and left button edges
// ----------------------------------------------------------------------------
module pmt_cursor #(
	parameter int COORD_BITS = pmt_pkg::COORD_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  pmt_pkg::packet_t         pkt,
	input  logic [pmt_pkg::POS_W-1:0] max_x,
	input  logic [pmt_pkg::POS_W-1:0] max_y,
	output pmt_pkg::result_t         res
);
	import pmt_pkg::*;

	localparam int               COORD_MASK = (1 << COORD_BITS) - 1;
	localparam logic [POS_W-1:0] CAP = (COORD_BITS >= POS_W) ? {POS_W{1'b1}}
		: POS_W'(COORD_MASK);
	localparam logic [POS_W-1:0] X_RST = POS_W'(CUR_X_RST & COORD_MASK);
	localparam logic [POS_W-1:0] Y_RST = POS_W'(CUR_Y_RST & COORD_MASK);

	logic [POS_W-1:0]        cur_x_q;
	logic [POS_W-1:0]        cur_y_q;
	logic                    prev_left_q;
	logic [7:0]              dx;
	logic [7:0]              dy;
	logic [POS_W-1:0]        lim_x;
	logic [POS_W-1:0]        lim_y;
	logic signed [POS_W+1:0] sum_x;
	logic signed [POS_W+1:0] sum_y;
	logic [POS_W-1:0]        nx;
	logic [POS_W-1:0]        ny;
	logic                    left;

	always_comb begin
		dx    = pkt.header[HDR_XOVF_BIT] ? 8'd0 : pkt.x_byte;
		dy    = pkt.header[HDR_YOVF_BIT] ? 8'd0 : pkt.y_byte;
		lim_x = (max_x > CAP) ? CAP : max_x;
		lim_y = (max_y > CAP) ? CAP : max_y;
		// y counts down the screen
		sum_x = $signed({2'b00, cur_x_q}) + $signed({{(POS_W-6){dx[7]}}, dx});
		sum_y = $signed({2'b00, cur_y_q}) - $signed({{(POS_W-6){dy[7]}}, dy});
		nx    = clamp_pos(sum_x, lim_x);
		ny    = clamp_pos(sum_y, lim_y);
		left  = pkt.header[LEFT_BIT];

		res.pos_x          = nx;
		res.pos_y          = ny;
		res.delta_x        = dx;
		res.delta_y        = dy;
		res.buttons        = pkt.header[2:0];
		res.left_went_down = left && !prev_left_q;
		res.left_went_up   = !left && prev_left_q;
		res.moved          = (nx != cur_x_q) || (ny != cur_y_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q     <= X_RST;
			cur_y_q     <= Y_RST;
			prev_left_q <= 1'b0;
		end else if (en) begin
			cur_x_q     <= nx;
			cur_y_q     <= ny;
			prev_left_q <= left;
		end
	end

endmodule

@@ rtl/core/ps2_mouse_packet_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_unit
// three-byte ps2 mouse packet decoder with clamped cursor tracking
// ----------------------------------------------------------------------------
// takes one raw mouse byte per clock on the data channel and gives one result
// transaction for every completed three-byte packet. a byte is registered in
// the input stage, decoded by the packet assembler and cursor logic in the
// next cycle and written to the result register, and one byte per cycle is
// accepted for as long as the result side keeps up; a byte that completes
// no packet never waits on the result side. in phase zero, bytes without
// bit 3 set are dropped. the cursor saturates at zero and at max_x / max_y
// (and at 2^COORD_BITS - 1 when that is lower); y is inverted. max_x and
// max_y are written through the cfg port and should only be changed while
// no transaction is in flight.
`include "ps2_mouse_packet_tracker_unit_defines.svh"

module ps2_mouse_packet_tracker_unit #(
	parameter int COORD_BITS = pmt_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_write_en,
	input  logic [pmt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pmt_pkg::POS_W-1:0]     cfg_data,
	// byte input
	input  logic                          data_valid,
	output logic                          data_stall,
	input  logic [7:0]                    data_byte,
	// results
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [pmt_pkg::POS_W-1:0]     pos_x,
	output logic [pmt_pkg::POS_W-1:0]     pos_y,
	output logic signed [7:0]             delta_x,
	output logic signed [7:0]             delta_y,
	output logic [2:0]                    buttons,
	output logic                          left_went_down,
	output logic                          left_went_up,
	output logic                          moved
);
	import pmt_pkg::*;

	// configuration registers
	logic [POS_W-1:0] max_x_q;
	logic [POS_W-1:0] max_y_q;

	// input stage
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             adv_s1;
	logic             load_s1;

	// decode
	logic             emit;
	packet_t          pkt;
	result_t          res;

	// result register
	logic             res_valid_q;
	result_t          res_q;
	logic             take;
	logic             load_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_x_q <= MAX_X_RST;
			max_y_q <= MAX_Y_RST;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_MAX_X: max_x_q <= cfg_data;
				REG_MAX_Y: max_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// the input stage moves on when its byte makes no result or the result
	// register is free or being emptied this cycle
	assign take       = res_valid_q && !result_stall;
	assign adv_s1     = valid_s1 && (!emit || !res_valid_q || !result_stall);
	assign load_res   = adv_s1 && emit;
	assign data_stall = valid_s1 && !adv_s1;
	assign load_s1    = data_valid && !data_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) byte_s1 <= data_byte;
	end

	pmt_assembler u_assembler (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv_s1),
		.data_byte (byte_s1),
		.emit      (emit),
		.pkt       (pkt)
	);

	pmt_cursor #(
		.COORD_BITS (COORD_BITS)
	) u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (load_res),
		.pkt    (pkt),
		.max_x  (max_x_q),
		.max_y  (max_y_q),
		.res    (res)
	);

	// result register, holds while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (take) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) res_q <= res;
	end

	assign result_valid   = res_valid_q;
	assign pos_x          = res_q.pos_x;
	assign pos_y          = res_q.pos_y;
	assign delta_x        = $signed(res_q.delta_x);
	assign delta_y        = $signed(res_q.delta_y);
	assign buttons        = res_q.buttons;
	assign left_went_down = res_q.left_went_down;
	assign left_went_up   = res_q.left_went_up;
	assign moved          = res_q.moved;

	// checks
	`PMT_ASSERT_NEXT(a_load_gives_result, clk, arst_n, load_res, res_valid_q,
		"completed packet did not reach the result register")
	`PMT_ASSERT_NOW(a_empty_stage_not_stalled, clk, arst_n, !valid_s1, !data_stall,
		"input stalled with an empty input stage")
	`PMT_ASSERT_NOW(a_left_edges_consistent, clk, arst_n, res_valid_q,
		(!(res_q.left_went_down && res_q.left_went_up)) &&
		(!res_q.left_went_down || res_q.buttons[LEFT_BIT]) &&
		(!res_q.left_went_up || !res_q.buttons[LEFT_BIT]),
		"left button edge flags disagree with button state")

endmodule

@@ test/mouse_packet_checker.sv @@
// ----------------------------------------------------------------------------
// mouse packet checker
// watches the byte and result channels of the packet tracker, predicts every
// decoded packet and compares each result transaction field by field
// ----------------------------------------------------------------------------
module mouse_packet_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [pmt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pmt_pkg::POS_W-1:0]     cfg_data,
	input  logic                          data_valid,
	input  logic                          data_stall,
	input  logic [7:0]                    data_byte,
	input  logic                          result_valid,
	input  logic                          result_stall,
	input  logic [pmt_pkg::POS_W-1:0]     pos_x,
	input  logic [pmt_pkg::POS_W-1:0]     pos_y,
	input  logic signed [7:0]             delta_x,
	input  logic signed [7:0]             delta_y,
	input  logic [2:0]                    buttons,
	input  logic                          left_went_down,
	input  logic                          left_went_up,
	input  logic                          moved,
	output int                            mismatches,
	output int                            packets_due
);
	timeunit 1ns;
	timeprecision 1ps;
	import pmt_pkg::*;

	localparam int COORD_TOP = (1 << COORD_BITS_DEF) - 1;

	logic [POS_W-1:0] lim_x, lim_y;
	logic [1:0]       byte_pos;
	logic [7:0]       hdr, x_raw;
	logic [POS_W-1:0] cur_x, cur_y;
	logic             last_left;
	result_t          packet_q[$];

	initial begin
		mismatches  = 0;
		packets_due = 0;
	end

	function automatic logic [POS_W-1:0] saturate(int v, logic [POS_W-1:0] reg_max);
		int lim;
		lim = int'(reg_max);
		if (lim > COORD_TOP)
			lim = COORD_TOP;
		if (v < 0)
			return '0;
		if (v > lim)
			return lim[POS_W-1:0];
		return v[POS_W-1:0];
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, want);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input int got, input int want);
		if (got != want)
			report(name, got, want);
	endtask

	// advance the packet assembler by one byte, queue a result on the third
	task automatic take_byte(input logic [7:0] b);
		int      dx, dy;
		logic    left;
		result_t r;
		if (byte_pos == 2'd0) begin
			if (!b[HDR_SYNC_BIT])
				return;
			hdr      = b;
			byte_pos = 2'd1;
			return;
		end
		if (byte_pos == 2'd1) begin
			x_raw    = b;
			byte_pos = 2'd2;
			return;
		end
		byte_pos = 2'd0;
		dx = int'($signed(x_raw));
		dy = int'($signed(b));
		if (hdr[HDR_XOVF_BIT])
			dx = 0;
		if (hdr[HDR_YOVF_BIT])
			dy = 0;
		left             = hdr[LEFT_BIT];
		r.pos_x          = saturate(int'(cur_x) + dx, lim_x);
		r.pos_y          = saturate(int'(cur_y) - dy, lim_y);
		r.delta_x        = dx[7:0];
		r.delta_y        = dy[7:0];
		r.buttons        = hdr[2:0];
		r.left_went_down = left & ~last_left;
		r.left_went_up   = ~left & last_left;
		r.moved          = (r.pos_x != cur_x) || (r.pos_y != cur_y);
		cur_x     = r.pos_x;
		cur_y     = r.pos_y;
		last_left = left;
		packet_q.push_back(r);
	endtask

	task automatic check_result();
		result_t want;
		if (packet_q.size() == 0) begin
			report("result transaction with no packet pending, pos_x", int'(pos_x), 0);
			return;
		end
		want = packet_q.pop_front();
		compare_field("pos_x", int'(pos_x), int'(want.pos_x));
		compare_field("pos_y", int'(pos_y), int'(want.pos_y));
		compare_field("delta_x", int'(delta_x), int'($signed(want.delta_x)));
		compare_field("delta_y", int'(delta_y), int'($signed(want.delta_y)));
		compare_field("buttons", int'(buttons), int'(want.buttons));
		compare_field("left_went_down", int'(left_went_down), int'(want.left_went_down));
		compare_field("left_went_up", int'(left_went_up), int'(want.left_went_up));
		compare_field("moved", int'(moved), int'(want.moved));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_x     = MAX_X_RST;
			lim_y     = MAX_Y_RST;
			byte_pos  = 2'd0;
			hdr       = '0;
			x_raw     = '0;
			cur_x     = POS_W'(CUR_X_RST & COORD_TOP);
			cur_y     = POS_W'(CUR_Y_RST & COORD_TOP);
			last_left = 1'b0;
			packet_q.delete();
			packets_due = 0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					REG_MAX_X: lim_x = cfg_data;
					REG_MAX_Y: lim_y = cfg_data;
					default: ;
				endcase
			end
			if (data_valid && !data_stall)
				take_byte(data_byte);
			if (result_valid && !result_stall)
				check_result();
			packets_due = packet_q.size();
		end
	end

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// packet tracker testbench
// feeds mouse byte streams through several cursor limit settings with random
// gaps and back-pressure; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import pmt_pkg::*;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = REG_MAX_X;
	logic [POS_W-1:0]     cfg_data     = '0;
	logic                 data_valid   = 1'b0;
	logic                 data_stall;
	logic [7:0]           data_byte    = 8'h00;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [POS_W-1:0]     pos_x, pos_y;
	logic signed [7:0]    delta_x, delta_y;
	logic [2:0]           buttons;
	logic                 left_went_down, left_went_up, moved;

	int mismatches;
	int packets_due;
	// bytes accepted so far, drives the hold-off and the no-idle window
	int bytes_sent = 0;

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	ps2_mouse_packet_tracker_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.data_valid    (data_valid),
		.data_stall    (data_stall),
		.data_byte     (data_byte),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.delta_x       (delta_x),
		.delta_y       (delta_y),
		.buttons       (buttons),
		.left_went_down(left_went_down),
		.left_went_up  (left_went_up),
		.moved         (moved)
	);

	mouse_packet_checker score (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.data_valid    (data_valid),
		.data_stall    (data_stall),
		.data_byte     (data_byte),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.delta_x       (delta_x),
		.delta_y       (delta_y),
		.buttons       (buttons),
		.left_went_down(left_went_down),
		.left_went_up  (left_went_up),
		.moved         (moved),
		.mismatches    (mismatches),
		.packets_due   (packets_due)
	);

	// stretch of the run where neither side idles
	function automatic bit no_idle_window();
		return (bytes_sent >= 450) && (bytes_sent < 600);
	endfunction

	// one byte transaction; valid stays high between back-to-back bytes
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (!no_idle_window() && $urandom_range(0, 99) < 7) begin
			gap = $urandom_range(1, 6);
			@(negedge clk) data_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		data_valid <= 1'b1;
		data_byte  <= b;
		// accepted at the first rising edge with stall low
		do @(posedge clk); while (data_stall);
		bytes_sent++;
	endtask

	task automatic send_packet(input logic [7:0] hdr, input logic [7:0] xb,
			input logic [7:0] yb);
		send_byte(hdr);
		send_byte(xb);
		send_byte(yb);
	endtask

	// movement byte, biased towards the extremes so the clamps are hit
	function automatic logic [7:0] pick_move();
		case ($urandom_range(0, 7))
			0: return 8'h7F;
			1: return 8'h80;
			2: return 8'h00;
			3: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// mostly well-formed packets with random content, the rest loose bytes
	// that get dropped or knock the assembler out of step
	task automatic random_traffic(input int n);
		int         i;
		logic [7:0] hdr;
		i = 0;
		while (i < n) begin
			if ($urandom_range(0, 99) < 85) begin
				hdr = 8'($urandom);
				hdr[HDR_SYNC_BIT] = 1'b1;
				if ($urandom_range(0, 99) < 75)
					hdr[HDR_YOVF_BIT:HDR_XOVF_BIT] = 2'b00;
				send_packet(hdr, pick_move(), pick_move());
				i += 3;
			end else begin
				send_byte(8'($urandom));
				i++;
			end
		end
	endtask

	// drop valid, let every expected result drain, then allow for a byte
	// still sitting in the pipeline that completes no packet
	task automatic settle();
		@(negedge clk) data_valid <= 1'b0;
		wait (packets_due == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limits(input logic [POS_W-1:0] mx, input logic [POS_W-1:0] my);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= REG_MAX_X;
		cfg_data     <= mx;
		@(negedge clk);
		cfg_index    <= REG_MAX_Y;
		cfg_data     <= my;
		@(negedge clk) cfg_write_en <= 1'b0;
	endtask

	// result side: random stalls, one long hold-off to back the block up
	initial begin
		int hold_left;
		bit held;
		hold_left = 0;
		held      = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && bytes_sent >= 300) begin
				held      = 1'b1;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else if (no_idle_window()) begin
				result_stall <= 1'b0;
			end else begin
				result_stall <= ($urandom_range(0, 99) < 7);
			end
		end
	end

	// main stimulus
	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed part, reset limits
		// bytes out of sync: all clear, and every bit but the sync bit
		send_byte(8'h00);
		send_byte(8'hF7);
		// largest right, largest down
		send_packet(8'h08, 8'h7F, 8'h80);
		// left goes down, largest left, largest up
		send_packet(8'h09, 8'h80, 8'h7F);
		// left goes up, right held, no movement
		send_packet(8'h0A, 8'h00, 8'h00);
		// both overflow flags, every button
		send_packet(8'hCF, 8'hFF, 8'h01);
		// x overflow only
		send_packet(8'h4C, 8'h55, 8'h81);
		// y overflow only, left pressed again
		send_packet(8'h8B, 8'h01, 8'hAA);
		random_traffic(60);
		settle();

		// widest limits, drive the cursor into the far corner
		set_limits(12'd4095, 12'd4095);
		repeat (36) send_packet(8'h08, 8'h7F, 8'h80);
		random_traffic(60);
		settle();

		// limits now below the cursor, next packet must pull it in
		set_limits(12'd30, 12'd17);
		random_traffic(100);
		settle();

		// zero limits, everything clamps to the origin
		set_limits(12'd0, 12'd0);
		random_traffic(60);
		settle();

		repeat (2) begin
			set_limits(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
			random_traffic(120);
			settle();
		end

		set_limits(12'd4095, 12'd0);
		random_traffic(60);
		settle();

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/pmt_pkg.sv
rtl/core/pmt_assembler.sv
rtl/core/pmt_cursor.sv
rtl/core/ps2_mouse_packet_tracker_unit.sv
test/mouse_packet_checker.sv
test/testbench.sv
